### rtl/assert_macros.svh
// Assertion macros shared by the router RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// A condition that must imply another in the same cycle.
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rstn, prop, msg)
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/mcpr_pkg.sv
// Types, codes and constants of the motion command priority router.
package mcpr_pkg;

    localparam int NSLOT = 3;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int TIME_BITS_DEF = 32;

    localparam logic [15:0] MAX_LIFE_RST = 16'd500;
    localparam logic [15:0] MAX_RLIFE_RST = 16'd200;

    localparam logic [1:0] SRC_AUTO = 2'd0;
    localparam logic [1:0] SRC_WIRELESS = 2'd1;
    localparam logic [1:0] SRC_LOCAL = 2'd2;
    localparam logic [1:0] SRC_NONE = 2'd3;

    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

    typedef enum logic [2:0] {
        CMD_SUBMIT      = 3'd0,
        CMD_CANCEL      = 3'd1,
        CMD_TICK        = 3'd2,
        CMD_ARM         = 3'd3,
        CMD_MAINT       = 3'd4,
        CMD_ESTOP       = 3'd5,
        CMD_CLEAR_ESTOP = 3'd6,
        CMD_NOP         = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_DISABLED  = 3'd1,
        RSN_SAFETY    = 3'd2,
        RSN_EMERGENCY = 3'd3,
        RSN_MAINT     = 3'd4,
        RSN_STALE     = 3'd5
    } reason_t;

    typedef enum logic [0:0] {
        CFG_MAX_LIFE  = 1'b0,
        CFG_MAX_RLIFE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEQ,
        ST_AGE,
        ST_FINISH
    } state_t;

    typedef enum logic {
        ALU_SEQ,
        ALU_AGE
    } alu_op_t;

    typedef struct packed {
        logic [31:0] diff;
        logic        zero;
        logic        neg;
        logic        ge;
    } alu_res_t;

    typedef struct packed {
        logic              ready;
        logic              load;
        logic              seq_step;
        logic              age_step;
        logic              finish;
        logic [SLOT_W-1:0] idx;
    } ctrl_t;

endpackage

### rtl/mcpr_alu.sv
// Shared subtract and compare unit for sequence and age checks.
module mcpr_alu #(
    parameter int TIME_BITS = mcpr_pkg::TIME_BITS_DEF
) (
    input  mcpr_pkg::alu_op_t  op,
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    input  logic [15:0]        c,
    output mcpr_pkg::alu_res_t res
);

    localparam logic [31:0] TMASK = 32'((64'd1 << TIME_BITS) - 64'd1);

    logic [31:0] raw;
    logic [31:0] diff;

    assign raw = a - b;
    assign diff = (op == mcpr_pkg::ALU_AGE) ? (raw & TMASK) : raw;

    assign res.diff = diff;
    assign res.zero = (diff == 32'd0);
    assign res.neg = raw[31];
    assign res.ge = (diff >= 32'(c));

endmodule

### rtl/mcpr_seq.sv
// Sequencer that steps one command through its check and commit cycles.
module mcpr_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  mcpr_pkg::cmd_t    s_cmd,
    input  logic              out_free,
    output mcpr_pkg::ctrl_t   ctrl
);

    localparam logic [mcpr_pkg::SLOT_W-1:0] LAST_IDX =
        mcpr_pkg::SLOT_W'(mcpr_pkg::NSLOT - 1);

    mcpr_pkg::state_t state_reg, state_next;
    logic [mcpr_pkg::SLOT_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcpr_pkg::ST_IDLE;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        ctrl = '0;
        ctrl.idx = idx_reg;
        case (state_reg)
            mcpr_pkg::ST_IDLE: begin
                ctrl.ready = 1'b1;
                idx_next = '0;
                if (s_valid) begin
                    ctrl.load = 1'b1;
                    case (s_cmd)
                        mcpr_pkg::CMD_SUBMIT: state_next = mcpr_pkg::ST_SEQ;
                        mcpr_pkg::CMD_TICK:   state_next = mcpr_pkg::ST_AGE;
                        default:              state_next = mcpr_pkg::ST_FINISH;
                    endcase
                end
            end
            mcpr_pkg::ST_SEQ: begin
                ctrl.seq_step = 1'b1;
                state_next = mcpr_pkg::ST_FINISH;
            end
            mcpr_pkg::ST_AGE: begin
                ctrl.age_step = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = mcpr_pkg::ST_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mcpr_pkg::ST_FINISH: begin
                // Commit only when the output register can take the beat.
                if (out_free) begin
                    ctrl.finish = 1'b1;
                    state_next = mcpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcpr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/motion_command_priority_router_unit.sv
// Top level of the motion command priority router.
// Takes one command beat at a time and returns one result beat for it. A tick
// walks the three slots through the shared subtract and compare unit, one slot
// a cycle, before it commits; a submit uses the unit once for the sequence
// check before it commits, and every other command goes straight to its commit.
// The result sits in an output register, so the next beat is taken while it
// waits; a command only stalls in its commit cycle if an earlier result is
// still not taken. Slot selection favors local over wireless over autonomous,
// and emergency stop stays latched until a clear-estop command arrives with no
// safety fault latched.
`include "assert_macros.svh"

module motion_command_priority_router_unit #(
    parameter int TIME_BITS = mcpr_pkg::TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [1:0]  s_source,
    input  logic [31:0] s_forward_bits,
    input  logic [31:0] s_turn_bits,
    input  logic [31:0] s_sequence_req,
    input  logic [15:0] s_lifetime_ms,
    input  logic [7:0]  s_enable_flag,
    input  logic [31:0] s_arrival_ms,
    input  logic [31:0] s_now_ms,
    input  logic        s_level_flag,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_apply_drive,
    output logic        m_stop_drive,
    output logic [31:0] m_out_forward,
    output logic [31:0] m_out_turn,
    output logic        m_out_enable,
    output logic [1:0]  m_drive_source,
    output logic [2:0]  m_halt_cause,
    output logic [3:0]  m_status_flags,
    output logic [31:0] m_rejected_total,
    output logic [31:0] m_expired_total
);

    localparam int NSLOT = mcpr_pkg::NSLOT;
    localparam int SLOT_W = mcpr_pkg::SLOT_W;

    mcpr_pkg::ctrl_t    ctrl;
    mcpr_pkg::alu_op_t  alu_op;
    mcpr_pkg::alu_res_t alu_res;
    logic [31:0]        alu_a, alu_b;
    logic [15:0]        alu_c;
    logic               out_free;

    // Latched command beat.
    mcpr_pkg::cmd_t cmd_reg;
    logic [1:0]     src_reg;
    logic [31:0]    fwd_reg, trn_reg, seq_reg, rcv_reg, now_reg;
    logic [15:0]    life_reg;
    logic [7:0]     en_reg;
    logic           lvl_reg;

    // Slot storage.
    logic [NSLOT-1:0]     slot_valid_reg, slot_valid_next;
    logic [31:0]          slot_fwd_reg [NSLOT];
    logic [31:0]          slot_trn_reg [NSLOT];
    logic [TIME_BITS-1:0] slot_rcv_reg [NSLOT];
    logic [15:0]          slot_life_reg [NSLOT];
    logic [31:0]          slot_seq_reg [NSLOT];
    logic                 slot_wr;

    // Router state.
    logic              fault_reg, fault_next;
    logic              active_reg, active_next;
    logic [1:0]        cur_src_reg, cur_src_next;
    mcpr_pkg::reason_t cur_rsn_reg, cur_rsn_next;
    logic              armed_reg, armed_next;
    logic              maint_reg, maint_next;
    logic              estop_reg, estop_next;
    logic [31:0]       rej_reg, rej_next;
    logic [31:0]       exp_reg, exp_next;
    logic [15:0]       max_life_reg, max_life_next;
    logic [15:0]       max_rlife_reg, max_rlife_next;
    logic              seq_bad_reg, seq_bad_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic        acc_reg, apply_reg, stop_reg;
    logic [31:0] ofwd_reg, otrn_reg;
    logic [1:0]  osrc_reg;
    logic [2:0]  orsn_reg;
    logic [3:0]  oflags_reg;
    logic [31:0] orej_reg, oexp_reg;

    logic [SLOT_W-1:0] src_idx, rd_idx, win_idx;
    logic              win_found;
    logic              acc, apply, stop_issued;
    logic              static_ok, age_hit;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = ctrl.ready;
    assign src_idx = (src_reg == mcpr_pkg::SRC_NONE) ? '0 : src_reg;

    mcpr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_cmd    (mcpr_pkg::cmd_t'(s_cmd)),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Highest valid slot wins: local over wireless over autonomous.
    always_comb begin
        win_idx = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_valid_reg[i]) begin
                win_idx = SLOT_W'(i);
            end
        end
    end
    assign win_found = |slot_valid_reg;

    always_comb begin
        if (ctrl.age_step) begin
            rd_idx = ctrl.idx;
        end else if (ctrl.seq_step) begin
            rd_idx = src_idx;
        end else begin
            rd_idx = win_idx;
        end
    end

    always_comb begin
        if (ctrl.age_step) begin
            alu_op = mcpr_pkg::ALU_AGE;
            alu_a = now_reg;
            alu_b = 32'(slot_rcv_reg[rd_idx]);
        end else begin
            alu_op = mcpr_pkg::ALU_SEQ;
            alu_a = seq_reg;
            alu_b = slot_seq_reg[rd_idx];
        end
        alu_c = slot_life_reg[rd_idx];
    end

    mcpr_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .res (alu_res)
    );

    assign static_ok = (src_reg != mcpr_pkg::SRC_NONE)
        && (fwd_reg[30:23] != mcpr_pkg::EXP_ALL_ONES)
        && (trn_reg[30:23] != mcpr_pkg::EXP_ALL_ONES)
        && (seq_reg != 32'd0)
        && (life_reg != 16'd0) && (life_reg <= max_life_reg)
        && (en_reg <= 8'd1)
        && ((src_reg == mcpr_pkg::SRC_LOCAL) || (life_reg <= max_rlife_reg));

    // Expiry is skipped when the tick reports a fault or estop is latched.
    assign age_hit = slot_valid_reg[rd_idx] && alu_res.ge && !lvl_reg && !estop_reg;

    always_comb begin
        slot_valid_next = slot_valid_reg;
        fault_next = fault_reg;
        active_next = active_reg;
        cur_src_next = cur_src_reg;
        cur_rsn_next = cur_rsn_reg;
        armed_next = armed_reg;
        maint_next = maint_reg;
        estop_next = estop_reg;
        rej_next = rej_reg;
        exp_next = exp_reg;
        max_life_next = max_life_reg;
        max_rlife_next = max_rlife_reg;
        seq_bad_next = seq_bad_reg;
        slot_wr = 1'b0;
        acc = 1'b0;
        apply = 1'b0;
        stop_issued = 1'b0;

        if (cfg_wr_en) begin
            case (mcpr_pkg::cfg_idx_t'(cfg_index))
                mcpr_pkg::CFG_MAX_LIFE:  max_life_next = cfg_data;
                mcpr_pkg::CFG_MAX_RLIFE: max_rlife_next = cfg_data;
                default: ;
            endcase
        end

        if (ctrl.seq_step) begin
            seq_bad_next = (alu_b != 32'd0) && (alu_res.zero || alu_res.neg);
        end

        if (ctrl.age_step && age_hit) begin
            slot_valid_next[rd_idx] = 1'b0;
            exp_next = exp_reg + 32'd1;
        end

        if (ctrl.finish) begin
            case (cmd_reg)
                mcpr_pkg::CMD_SUBMIT: begin
                    if (!static_ok || fault_reg) begin
                        rej_next = rej_reg + 32'd1;
                    end else if (en_reg == 8'd0) begin
                        acc = 1'b1;
                        slot_valid_next[src_idx] = 1'b0;
                        if (cur_src_reg == src_reg && active_reg) begin
                            active_next = 1'b0;
                            cur_src_next = mcpr_pkg::SRC_NONE;
                            cur_rsn_next = mcpr_pkg::RSN_DISABLED;
                            stop_issued = 1'b1;
                        end
                    end else if (maint_reg || estop_reg
                                 || (src_reg != mcpr_pkg::SRC_LOCAL && !armed_reg)
                                 || seq_bad_reg) begin
                        rej_next = rej_reg + 32'd1;
                    end else begin
                        acc = 1'b1;
                        slot_wr = 1'b1;
                        slot_valid_next[src_idx] = 1'b1;
                    end
                end
                mcpr_pkg::CMD_CANCEL: begin
                    if (src_reg != mcpr_pkg::SRC_NONE) begin
                        acc = 1'b1;
                        slot_valid_next[src_idx] = 1'b0;
                        if (cur_src_reg == src_reg && active_reg) begin
                            active_next = 1'b0;
                            cur_src_next = mcpr_pkg::SRC_NONE;
                            cur_rsn_next = mcpr_pkg::RSN_DISABLED;
                            stop_issued = 1'b1;
                        end
                    end
                end
                mcpr_pkg::CMD_TICK: begin
                    acc = 1'b1;
                    fault_next = lvl_reg;
                    if (lvl_reg) begin
                        armed_next = 1'b0;
                        slot_valid_next = '0;
                        active_next = 1'b0;
                        cur_src_next = mcpr_pkg::SRC_NONE;
                        cur_rsn_next = mcpr_pkg::RSN_SAFETY;
                        stop_issued = 1'b1;
                    end else if (estop_reg) begin
                        active_next = 1'b0;
                        cur_src_next = mcpr_pkg::SRC_NONE;
                        cur_rsn_next = mcpr_pkg::RSN_EMERGENCY;
                        stop_issued = 1'b1;
                    end else if (maint_reg) begin
                        slot_valid_next = '0;
                        active_next = 1'b0;
                        cur_src_next = mcpr_pkg::SRC_NONE;
                        cur_rsn_next = mcpr_pkg::RSN_MAINT;
                        stop_issued = 1'b1;
                    end else if (win_found) begin
                        apply = 1'b1;
                        active_next = 1'b1;
                        cur_src_next = 2'(win_idx);
                        cur_rsn_next = mcpr_pkg::RSN_NONE;
                    end else begin
                        // A stop is only issued if something was driving.
                        stop_issued = active_reg;
                        active_next = 1'b0;
                        cur_src_next = mcpr_pkg::SRC_NONE;
                        cur_rsn_next = mcpr_pkg::RSN_STALE;
                    end
                end
                mcpr_pkg::CMD_ARM: begin
                    if (!lvl_reg) begin
                        armed_next = 1'b0;
                        acc = 1'b1;
                    end else if (!fault_reg && !maint_reg && !estop_reg) begin
                        armed_next = 1'b1;
                        acc = 1'b1;
                    end
                end
                mcpr_pkg::CMD_MAINT: begin
                    acc = 1'b1;
                    maint_next = lvl_reg;
                    armed_next = 1'b0;
                    slot_valid_next = '0;
                    active_next = 1'b0;
                    cur_src_next = mcpr_pkg::SRC_NONE;
                    cur_rsn_next = lvl_reg ? mcpr_pkg::RSN_MAINT : mcpr_pkg::RSN_DISABLED;
                    stop_issued = 1'b1;
                end
                mcpr_pkg::CMD_ESTOP: begin
                    acc = 1'b1;
                    estop_next = 1'b1;
                    armed_next = 1'b0;
                    slot_valid_next = '0;
                    active_next = 1'b0;
                    cur_src_next = mcpr_pkg::SRC_NONE;
                    cur_rsn_next = mcpr_pkg::RSN_EMERGENCY;
                    stop_issued = 1'b1;
                end
                mcpr_pkg::CMD_CLEAR_ESTOP: begin
                    if (!fault_reg) begin
                        acc = 1'b1;
                        estop_next = 1'b0;
                        active_next = 1'b0;
                        cur_src_next = mcpr_pkg::SRC_NONE;
                        cur_rsn_next = mcpr_pkg::RSN_DISABLED;
                        stop_issued = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid_next = ctrl.finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            fault_reg <= 1'b0;
            active_reg <= 1'b0;
            cur_src_reg <= mcpr_pkg::SRC_NONE;
            cur_rsn_reg <= mcpr_pkg::RSN_DISABLED;
            armed_reg <= 1'b0;
            maint_reg <= 1'b0;
            estop_reg <= 1'b0;
            rej_reg <= '0;
            exp_reg <= '0;
            max_life_reg <= mcpr_pkg::MAX_LIFE_RST;
            max_rlife_reg <= mcpr_pkg::MAX_RLIFE_RST;
            seq_bad_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
                slot_seq_reg[i] <= '0;
            end
        end else begin
            slot_valid_reg <= slot_valid_next;
            fault_reg <= fault_next;
            active_reg <= active_next;
            cur_src_reg <= cur_src_next;
            cur_rsn_reg <= cur_rsn_next;
            armed_reg <= armed_next;
            maint_reg <= maint_next;
            estop_reg <= estop_next;
            rej_reg <= rej_next;
            exp_reg <= exp_next;
            max_life_reg <= max_life_next;
            max_rlife_reg <= max_rlife_next;
            seq_bad_reg <= seq_bad_next;
            m_valid_reg <= m_valid_next;
            if (slot_wr) begin
                slot_seq_reg[src_idx] <= seq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg <= mcpr_pkg::cmd_t'(s_cmd);
            src_reg <= s_source;
            fwd_reg <= s_forward_bits;
            trn_reg <= s_turn_bits;
            seq_reg <= s_sequence_req;
            life_reg <= s_lifetime_ms;
            en_reg <= s_enable_flag;
            rcv_reg <= s_arrival_ms;
            now_reg <= s_now_ms;
            lvl_reg <= s_level_flag;
        end
        if (slot_wr) begin
            slot_fwd_reg[src_idx] <= fwd_reg;
            slot_trn_reg[src_idx] <= trn_reg;
            slot_rcv_reg[src_idx] <= rcv_reg[TIME_BITS-1:0];
            slot_life_reg[src_idx] <= life_reg;
        end
        if (ctrl.finish) begin
            acc_reg <= acc;
            apply_reg <= apply;
            stop_reg <= stop_issued;
            ofwd_reg <= apply ? slot_fwd_reg[rd_idx] : 32'd0;
            otrn_reg <= apply ? slot_trn_reg[rd_idx] : 32'd0;
            osrc_reg <= cur_src_next;
            orsn_reg <= cur_rsn_next;
            oflags_reg <= {fault_next, estop_next, maint_next, armed_next};
            orej_reg <= rej_next;
            oexp_reg <= exp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_accepted = acc_reg;
    assign m_apply_drive = apply_reg;
    assign m_stop_drive = stop_reg;
    assign m_out_forward = ofwd_reg;
    assign m_out_turn = otrn_reg;
    // A valid slot always carries drive enabled, so the applied enable
    // follows the apply flag.
    assign m_out_enable = apply_reg;
    assign m_drive_source = osrc_reg;
    assign m_halt_cause = orsn_reg;
    assign m_status_flags = oflags_reg;
    assign m_rejected_total = orej_reg;
    assign m_expired_total = oexp_reg;

    `AST_IMPLIES(a_apply_xor_stop, aclk, aresetn, m_valid, !(m_apply_drive && m_stop_drive), "apply and stop in one beat")
    `AST_IMPLIES(a_apply_has_src, aclk, aresetn, m_valid && m_apply_drive, (m_drive_source != mcpr_pkg::SRC_NONE) && (m_halt_cause == mcpr_pkg::RSN_NONE), "apply without an active source")
    `AST_IMPLIES(a_stop_no_src, aclk, aresetn, m_valid && m_stop_drive, m_drive_source == mcpr_pkg::SRC_NONE, "stop left a source active")
    `AST_HOLDS(a_arm_blocked, aclk, aresetn, !(armed_reg && (estop_reg || maint_reg)), "armed while estop or maintenance")
    `AST_HOLDS(a_exp_step, aclk, aresetn, 1'b1 |=> ((exp_reg == $past(exp_reg)) || (exp_reg == 32'($past(exp_reg) + 32'd1))), "expire count jumped")

endmodule

### verif/motion_command_priority_router_unit_tb.sv
// Self-checking testbench for the motion command priority router with a built-in predictor.
`timescale 1ns / 100ps

module motion_command_priority_router_unit_tb;
    import mcpr_pkg::*;

    localparam int PHASE_ITEMS = 334;
    localparam int PHASES = 6;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        cmd_t        cmd;
        logic [1:0]  source;
        logic [31:0] forward_bits;
        logic [31:0] turn_bits;
        logic [31:0] sequence_req;
        logic [15:0] lifetime_ms;
        logic [7:0]  enable_flag;
        logic [31:0] arrival_ms;
        logic [31:0] now_ms;
        logic        level_flag;
    } route_cmd_t;

    typedef struct packed {
        logic        accepted;
        logic        apply_drive;
        logic        stop_drive;
        logic [31:0] out_forward;
        logic [31:0] out_turn;
        logic        out_enable;
        logic [1:0]  drive_source;
        logic [2:0]  halt_cause;
        logic [3:0]  status_flags;
        logic [31:0] rejected_total;
        logic [31:0] expired_total;
    } route_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = CFG_MAX_LIFE;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = CMD_NOP;
    logic [1:0]  s_source = '0;
    logic [31:0] s_forward_bits = '0;
    logic [31:0] s_turn_bits = '0;
    logic [31:0] s_sequence_req = '0;
    logic [15:0] s_lifetime_ms = '0;
    logic [7:0]  s_enable_flag = '0;
    logic [31:0] s_arrival_ms = '0;
    logic [31:0] s_now_ms = '0;
    logic        s_level_flag = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic        m_apply_drive;
    logic        m_stop_drive;
    logic [31:0] m_out_forward;
    logic [31:0] m_out_turn;
    logic        m_out_enable;
    logic [1:0]  m_drive_source;
    logic [2:0]  m_halt_cause;
    logic [3:0]  m_status_flags;
    logic [31:0] m_rejected_total;
    logic [31:0] m_expired_total;

    motion_command_priority_router_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_source(s_source),
        .s_forward_bits(s_forward_bits),
        .s_turn_bits(s_turn_bits),
        .s_sequence_req(s_sequence_req),
        .s_lifetime_ms(s_lifetime_ms),
        .s_enable_flag(s_enable_flag),
        .s_arrival_ms(s_arrival_ms),
        .s_now_ms(s_now_ms),
        .s_level_flag(s_level_flag),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_accepted(m_accepted),
        .m_apply_drive(m_apply_drive),
        .m_stop_drive(m_stop_drive),
        .m_out_forward(m_out_forward),
        .m_out_turn(m_out_turn),
        .m_out_enable(m_out_enable),
        .m_drive_source(m_drive_source),
        .m_halt_cause(m_halt_cause),
        .m_status_flags(m_status_flags),
        .m_rejected_total(m_rejected_total),
        .m_expired_total(m_expired_total)
    );

    always #6 aclk = ~aclk;

    route_cmd_t command_backlog[$];
    route_res_t outcomes_due[$];
    int         mismatch_count = 0;
    int         results_seen = 0;
    logic       cmd_taken = 1'b0;
    int         quiet_cycles = 0;

    // Predictor state: the slot table and router status as the block should hold them.
    logic        slot_live [3];
    logic [31:0] slot_fwd [3];
    logic [31:0] slot_trn [3];
    logic        slot_en [3];
    logic [31:0] slot_rcv [3];
    logic [15:0] slot_life [3];
    logic [31:0] slot_seq [3];
    logic        fault_q;
    logic        drive_on;
    logic [1:0]  cur_src;
    reason_t     cur_rsn;
    logic        armed_q;
    logic        maint_q;
    logic        estop_q;
    logic [31:0] rej_cnt;
    logic [31:0] exp_cnt;
    logic [15:0] lim_any;
    logic [15:0] lim_remote;
    logic        stop_hit;

    function automatic void note_error(input string msg);
        if (mismatch_count < 10)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            note_error($sformatf("%s expected 0x%08h, got 0x%08h", name, want, got));
    endfunction

    function automatic void halt_drive(input reason_t why);
        drive_on = 1'b0;
        cur_src = SRC_NONE;
        cur_rsn = why;
        stop_hit = 1'b1;
    endfunction

    function automatic void drop_all_slots();
        for (int i = 0; i < 3; i++)
            slot_live[i] = 1'b0;
    endfunction

    function automatic void withdraw_source(input logic [1:0] src);
        slot_live[src] = 1'b0;
        if (cur_src == src && drive_on)
            halt_drive(RSN_DISABLED);
    endfunction

    function automatic route_res_t route_command(input route_cmd_t c);
        route_res_t  r;
        int          win;
        logic        ok;
        logic [31:0] diff;
        logic [31:0] age;
        r = '0;
        win = -1;
        stop_hit = 1'b0;
        case (c.cmd)
            CMD_SUBMIT: begin
                ok = c.source != SRC_NONE && c.forward_bits[30:23] != EXP_ALL_ONES &&
                     c.turn_bits[30:23] != EXP_ALL_ONES && c.sequence_req != 0 &&
                     c.lifetime_ms >= 16'd1 && c.lifetime_ms <= lim_any &&
                     c.enable_flag <= 8'd1;
                if (ok && c.source != SRC_LOCAL && c.lifetime_ms > lim_remote)
                    ok = 1'b0;
                if (!ok || fault_q) begin
                    rej_cnt++;
                end else if (c.enable_flag == 8'd0) begin
                    withdraw_source(c.source);
                    r.accepted = 1'b1;
                end else if (maint_q || estop_q || (c.source != SRC_LOCAL && !armed_q)) begin
                    rej_cnt++;
                end else begin
                    // Sequence must be strictly newer by signed wrap difference.
                    diff = c.sequence_req - slot_seq[c.source];
                    if (slot_seq[c.source] != 0 && (diff == 0 || diff[31])) begin
                        rej_cnt++;
                    end else begin
                        slot_fwd[c.source] = c.forward_bits;
                        slot_trn[c.source] = c.turn_bits;
                        slot_en[c.source] = 1'b1;
                        slot_rcv[c.source] = c.arrival_ms;
                        slot_life[c.source] = c.lifetime_ms;
                        slot_seq[c.source] = c.sequence_req;
                        slot_live[c.source] = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
            end
            CMD_CANCEL: begin
                if (c.source != SRC_NONE) begin
                    withdraw_source(c.source);
                    r.accepted = 1'b1;
                end
            end
            CMD_TICK: begin
                r.accepted = 1'b1;
                fault_q = c.level_flag;
                if (c.level_flag) begin
                    armed_q = 1'b0;
                    drop_all_slots();
                    halt_drive(RSN_SAFETY);
                end else if (estop_q) begin
                    halt_drive(RSN_EMERGENCY);
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (slot_live[i]) begin
                            age = c.now_ms - slot_rcv[i];
                            if (age >= {16'd0, slot_life[i]}) begin
                                slot_live[i] = 1'b0;
                                exp_cnt++;
                            end
                        end
                    end
                    if (maint_q) begin
                        drop_all_slots();
                        halt_drive(RSN_MAINT);
                    end else begin
                        for (int i = 2; i >= 0; i--)
                            if (slot_live[i] && win < 0)
                                win = i;
                        if (win >= 0) begin
                            drive_on = 1'b1;
                            cur_src = win[1:0];
                            cur_rsn = RSN_NONE;
                        end else if (drive_on) begin
                            halt_drive(RSN_STALE);
                        end else begin
                            cur_src = SRC_NONE;
                            cur_rsn = RSN_STALE;
                        end
                    end
                end
            end
            CMD_ARM: begin
                if (!c.level_flag) begin
                    armed_q = 1'b0;
                    r.accepted = 1'b1;
                end else if (!fault_q && !maint_q && !estop_q) begin
                    armed_q = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            CMD_MAINT: begin
                maint_q = c.level_flag;
                armed_q = 1'b0;
                drop_all_slots();
                halt_drive(c.level_flag ? RSN_MAINT : RSN_DISABLED);
                r.accepted = 1'b1;
            end
            CMD_ESTOP: begin
                estop_q = 1'b1;
                armed_q = 1'b0;
                drop_all_slots();
                halt_drive(RSN_EMERGENCY);
                r.accepted = 1'b1;
            end
            CMD_CLEAR_ESTOP: begin
                if (!fault_q) begin
                    estop_q = 1'b0;
                    halt_drive(RSN_DISABLED);
                    r.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (win >= 0) begin
            r.apply_drive = 1'b1;
            r.out_forward = slot_fwd[win];
            r.out_turn = slot_trn[win];
            r.out_enable = slot_en[win];
        end
        r.stop_drive = stop_hit;
        r.drive_source = cur_src;
        r.halt_cause = cur_rsn;
        r.status_flags = {fault_q, estop_q, maint_q, armed_q};
        r.rejected_total = rej_cnt;
        r.expired_total = exp_cnt;
        return r;
    endfunction

    function automatic route_cmd_t make_cmd(input cmd_t op, input logic [1:0] src,
                                            input logic [31:0] fwd, input logic [31:0] trn,
                                            input logic [31:0] seq, input logic [15:0] life,
                                            input logic [7:0] en, input logic [31:0] rcv,
                                            input logic [31:0] now, input logic lvl);
        route_cmd_t c;
        c.cmd = op;
        c.source = src;
        c.forward_bits = fwd;
        c.turn_bits = trn;
        c.sequence_req = seq;
        c.lifetime_ms = life;
        c.enable_flag = en;
        c.arrival_ms = rcv;
        c.now_ms = now;
        c.level_flag = lvl;
        return c;
    endfunction

    // Monitor and predictor: results are checked before the new command beat is predicted.
    always @(posedge aclk) begin : monitor_proc
        route_cmd_t taken;
        route_res_t seen;
        route_res_t want;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                slot_live[i] = 1'b0;
                slot_fwd[i] = '0;
                slot_trn[i] = '0;
                slot_en[i] = 1'b0;
                slot_rcv[i] = '0;
                slot_life[i] = '0;
                slot_seq[i] = '0;
            end
            fault_q = 1'b0;
            drive_on = 1'b0;
            cur_src = SRC_NONE;
            cur_rsn = RSN_DISABLED;
            armed_q = 1'b0;
            maint_q = 1'b0;
            estop_q = 1'b0;
            rej_cnt = '0;
            exp_cnt = '0;
            lim_any = MAX_LIFE_RST;
            lim_remote = MAX_RLIFE_RST;
            cmd_taken <= 1'b0;
            results_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAX_LIFE:  lim_any = cfg_data;
                    CFG_MAX_RLIFE: lim_remote = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                seen = {m_accepted, m_apply_drive, m_stop_drive, m_out_forward, m_out_turn,
                        m_out_enable, m_drive_source, m_halt_cause, m_status_flags,
                        m_rejected_total, m_expired_total};
                if (outcomes_due.size() == 0) begin
                    note_error("result beat arrived with no command outstanding");
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
                    check_field("apply_drive", 32'(want.apply_drive), 32'(seen.apply_drive));
                    check_field("stop_drive", 32'(want.stop_drive), 32'(seen.stop_drive));
                    check_field("out_forward", want.out_forward, seen.out_forward);
                    check_field("out_turn", want.out_turn, seen.out_turn);
                    check_field("out_enable", 32'(want.out_enable), 32'(seen.out_enable));
                    check_field("drive_source", 32'(want.drive_source),
                                32'(seen.drive_source));
                    check_field("halt_cause", 32'(want.halt_cause), 32'(seen.halt_cause));
                    check_field("status_flags", 32'(want.status_flags),
                                32'(seen.status_flags));
                    check_field("rejected_total", want.rejected_total, seen.rejected_total);
                    check_field("expired_total", want.expired_total, seen.expired_total);
                end
            end
            cmd_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                taken = make_cmd(cmd_t'(s_cmd), s_source, s_forward_bits, s_turn_bits,
                                 s_sequence_req, s_lifetime_ms, s_enable_flag, s_arrival_ms,
                                 s_now_ms, s_level_flag);
                outcomes_due.push_back(route_command(taken));
            end
        end
    end

    // Command driver: bursts of beats separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin : driver_proc
        route_cmd_t next_cmd;
        if (aresetn && (!s_valid || cmd_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
                next_cmd = command_backlog.pop_front();
                s_cmd <= next_cmd.cmd;
                s_source <= next_cmd.source;
                s_forward_bits <= next_cmd.forward_bits;
                s_turn_bits <= next_cmd.turn_bits;
                s_sequence_req <= next_cmd.sequence_req;
                s_lifetime_ms <= next_cmd.lifetime_ms;
                s_enable_flag <= next_cmd.enable_flag;
                s_arrival_ms <= next_cmd.arrival_ms;
                s_now_ms <= next_cmd.now_ms;
                s_level_flag <= next_cmd.level_flag;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: the stall pattern steps with a phase counter, plus one long hold-off
    // that lets the block fill up and push back on its command input.
    logic [15:0] rx_phase = '0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (rx_phase[7:6])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= $urandom_range(0, 3) != 0;
                2'd2:    m_ready <= $urandom_range(0, 3) == 0;
                default: m_ready <= rx_phase[2:0] < 3'd5;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic settle();
        while (command_backlog.size() != 0 || s_valid || outcomes_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        route_cmd_t  item;
        logic [31:0] gen_seq [3];
        logic [31:0] gen_ms;
        logic [15:0] gen_life;
        logic [15:0] gen_rlife;
        logic [15:0] lim;
        logic [1:0]  src;
        int          pick;
        int          roll;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening: field extremes, every command and the documented corner cases.
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 5, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h7F7F_FFFF, 32'h8000_0000,
                                           1, 100, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 10, 1'b0));
        command_backlog.push_back(make_cmd(CMD_ARM, SRC_NONE, 0, 0, 0, 0, 0, 0, 10, 1'b1));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_WIRELESS, 32'hFF7F_FFFF, 32'h1,
                                           5, 200, 1, 0, 0, 1'b0));
        // Same sequence again is not newer.
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_WIRELESS, 32'h1, 32'h1,
                                           5, 200, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h7F80_0000, 32'h1,
                                           2, 10, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h1, 32'h1,
                                           2, 0, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_WIRELESS, 32'h1, 32'h1,
                                           6, 201, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h1, 32'h1,
                                           2, 10, 8'hFF, 0, 0, 1'b0));
        // Half-range jump is still newer; jumping back from it is not.
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h0, 32'h0080_0000,
                                           32'h8000_0000, 500, 1, 32'hFFFF_FFF0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h1, 32'h1,
                                           1, 500, 1, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 5, 1'b0));
        // Withdraw of the driving source with an old sequence.
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h1, 32'h1,
                                           1, 1, 0, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 100, 1'b0));
        command_backlog.push_back(make_cmd(CMD_CANCEL, SRC_NONE, 0, 0, 0, 0, 0, 0, 100, 1'b0));
        command_backlog.push_back(make_cmd(CMD_CANCEL, SRC_WIRELESS, 0, 0, 0, 0, 0, 0, 100,
                                           1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 150, 1'b1));
        command_backlog.push_back(make_cmd(CMD_CLEAR_ESTOP, SRC_NONE, 0, 0, 0, 0, 0, 0, 150,
                                           1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 200, 1'b0));
        command_backlog.push_back(make_cmd(CMD_MAINT, SRC_NONE, 0, 0, 0, 0, 0, 0, 200, 1'b1));
        command_backlog.push_back(make_cmd(CMD_ARM, SRC_NONE, 0, 0, 0, 0, 0, 0, 200, 1'b1));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 210, 1'b0));
        command_backlog.push_back(make_cmd(CMD_MAINT, SRC_NONE, 0, 0, 0, 0, 0, 0, 210, 1'b0));
        command_backlog.push_back(make_cmd(CMD_ESTOP, SRC_NONE, 0, 0, 0, 0, 0, 0, 210, 1'b0));
        // Withdraw is honored even under emergency stop.
        command_backlog.push_back(make_cmd(CMD_SUBMIT, SRC_LOCAL, 32'h1, 32'h1,
                                           2, 5, 0, 0, 0, 1'b0));
        command_backlog.push_back(make_cmd(CMD_TICK, SRC_NONE, 0, 0, 0, 0, 0, 0, 220, 1'b0));
        command_backlog.push_back(make_cmd(CMD_CLEAR_ESTOP, SRC_NONE, 0, 0, 0, 0, 0, 0, 220,
                                           1'b0));
        command_backlog.push_back(make_cmd(CMD_ARM, SRC_NONE, 0, 0, 0, 0, 0, 0, 220, 1'b0));
        command_backlog.push_back(make_cmd(CMD_NOP, SRC_NONE, 0, 0, 0, 0, 0, 0, 220, 1'b0));
        settle();

        // Sequences start close to the wrap points so they cross them during the run.
        gen_seq[0] = 32'h7FFF_FF80;
        gen_seq[1] = 32'h7FFF_FF80;
        gen_seq[2] = 32'hFFFF_FF80;
        gen_ms = $urandom;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    gen_life = MAX_LIFE_RST;
                    gen_rlife = MAX_RLIFE_RST;
                end
                1: begin
                    gen_life = 16'hFFFF;
                    gen_rlife = 16'hFFFF;
                end
                2: begin
                    gen_life = 16'd1;
                    gen_rlife = 16'd1;
                end
                3: begin
                    gen_life = 16'd300;
                    gen_rlife = 16'd0;
                end
                4: begin
                    gen_life = 16'($urandom_range(1, 65535));
                    gen_rlife = 16'($urandom_range(1, 1000));
                end
                default: begin
                    gen_life = 16'($urandom_range(1, 800));
                    gen_rlife = 16'($urandom_range(1, 800));
                end
            endcase
            write_reg(CFG_MAX_LIFE, gen_life);
            write_reg(CFG_MAX_RLIFE, gen_rlife);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                item = make_cmd(CMD_NOP, 2'($urandom_range(0, 3)), $urandom, $urandom,
                                $urandom, 16'($urandom), 8'($urandom), $urandom, gen_ms,
                                1'($urandom_range(0, 1)));
                if (pick < 40) begin
                    // Mostly well-formed submit with random drive content.
                    src = ($urandom_range(0, 19) == 0) ? SRC_NONE : 2'($urandom_range(0, 2));
                    item.cmd = CMD_SUBMIT;
                    item.source = src;
                    if (item.forward_bits[30:23] == EXP_ALL_ONES && $urandom_range(0, 7) != 0)
                        item.forward_bits[23] = 1'b0;
                    if (item.turn_bits[30:23] == EXP_ALL_ONES && $urandom_range(0, 7) != 0)
                        item.turn_bits[23] = 1'b0;
                    if (src != SRC_NONE) begin
                        gen_seq[src] = gen_seq[src] + $urandom_range(1, 3);
                        item.sequence_req = ($urandom_range(0, 19) == 0) ?
                                            gen_seq[src] - $urandom_range(0, 4) : gen_seq[src];
                    end
                    lim = (src == SRC_LOCAL || gen_rlife > gen_life) ? gen_life : gen_rlife;
                    roll = $urandom_range(0, 19);
                    if (lim == 0)
                        item.lifetime_ms = 16'($urandom_range(0, 2));
                    else if (roll == 0)
                        item.lifetime_ms = lim + 1'b1;
                    else if (roll < 5)
                        item.lifetime_ms = 16'($urandom_range(1, lim));
                    else
                        item.lifetime_ms = 16'($urandom_range(1, (lim > 400) ? 400 : lim));
                    roll = $urandom_range(0, 19);
                    item.enable_flag = (roll < 2) ? 8'd0 :
                                       (roll == 2) ? 8'($urandom_range(2, 255)) : 8'd1;
                    item.arrival_ms = gen_ms - $urandom_range(0, 20);
                end else if (pick < 65) begin
                    gen_ms = gen_ms + $urandom_range(0, 150);
                    item.cmd = CMD_TICK;
                    item.now_ms = gen_ms;
                    item.level_flag = ($urandom_range(0, 29) == 0);
                end else if (pick < 73) begin
                    item.cmd = CMD_ARM;
                    item.level_flag = ($urandom_range(0, 4) != 0);
                end else if (pick < 77) begin
                    item.cmd = CMD_CANCEL;
                end else if (pick < 80) begin
                    item.cmd = CMD_MAINT;
                    item.level_flag = ($urandom_range(0, 4) == 0);
                end else if (pick < 82) begin
                    item.cmd = CMD_ESTOP;
                end else if (pick < 88) begin
                    item.cmd = CMD_CLEAR_ESTOP;
                end else begin
                    // Noise: any command code with fully random fields.
                    item.cmd = cmd_t'($urandom_range(0, 7));
                    item.now_ms = $urandom;
                end
                command_backlog.push_back(item);
            end
            settle();
        end

        repeat (20) @(negedge aclk);
        if (outcomes_due.size() != 0)
            note_error($sformatf("%0d results never arrived", outcomes_due.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
